[rtl/sci_pkg.sv]
// Shared constants and types of the segment corridor ink check.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package sci_pkg;

  localparam int FRAME_WIDTH  = 256;
  localparam int FRAME_HEIGHT = 256;
  localparam int FRAME_DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int ADDR_W       = $clog2(FRAME_DEPTH);
  localparam int INK_LIMIT    = 200;

  localparam int SQ_W    = 34;
  localparam int ROOT_W  = 17;
  localparam int N_W     = 13;
  localparam int CNT_W   = 18;
  localparam int DIV_N_W = 34;
  localparam int DIV_D_W = 18;

  localparam logic [1:0] CFG_MIN_LENGTH  = 2'd0;
  localparam logic [1:0] CFG_HALF_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_MIN_DENSITY = 2'd2;

  localparam logic [1:0] VERDICT_ACCEPT = 2'd0;
  localparam logic [1:0] VERDICT_SHORT  = 2'd1;
  localparam logic [1:0] VERDICT_INK    = 2'd2;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_WRITE,
    CMD_CAPTURE,
    CMD_SQUARE,
    CMD_SUM,
    CMD_ROOT_STEP,
    CMD_LENGTH,
    CMD_SCALE,
    CMD_TERMS,
    CMD_DIVX_GO,
    CMD_DIVX_END,
    CMD_DIVY_GO,
    CMD_DIVY_END,
    CMD_SAMPLE,
    CMD_DENS_GO,
    CMD_DENS_END,
    CMD_PRODUCT,
    CMD_VERDICT,
    CMD_RESULT
  } sci_cmd_t;

  typedef struct packed {
    logic root_last;
    logic is_short;
    logic is_zero;
    logic div_done;
    logic samp_last;
    logic no_samples;
    logic out_free;
  } sci_status_t;

endpackage

[rtl/sci_div.sv]
// Restoring divider, one quotient bit per cycle.
// Depends on sci_pkg for its widths.
`timescale 1ns / 1ps

module sci_div import sci_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [DIV_N_W-1:0] dividend,
  input  logic [DIV_D_W-1:0] divisor,
  output logic               done,
  output logic [DIV_N_W-1:0] quotient,
  output logic [DIV_D_W-1:0] remainder
);

  localparam int DCNT_W = $clog2(DIV_N_W + 1);

  logic [DIV_N_W-1:0] quo_r, quo_nxt;
  logic [DIV_D_W-1:0] rem_r, rem_nxt;
  logic [DIV_D_W-1:0] dvs_r, dvs_nxt;
  logic [DCNT_W-1:0]  cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [DIV_D_W:0]   rem_t;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    rem_t    = {rem_r, quo_r[DIV_N_W-1]};
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = DCNT_W'(DIV_N_W - 1);
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      if (rem_t >= {1'b0, dvs_r}) begin
        rem_nxt = DIV_D_W'(rem_t - {1'b0, dvs_r});
        quo_nxt = {quo_r[DIV_N_W-2:0], 1'b1};
      end else begin
        rem_nxt = DIV_D_W'(rem_t);
        quo_nxt = {quo_r[DIV_N_W-2:0], 1'b0};
      end
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

[rtl/sci_dp.sv]
// Datapath: frame memory, length root, point stepping, sampling and result register.
// Depends on sci_pkg and sci_div; driven by commands from sci_ctrl.
`timescale 1ns / 1ps

module sci_dp import sci_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  sci_cmd_t           cmd,
  input  logic [16:0]        cfg_min_length,
  input  logic [7:0]         cfg_half_width,
  input  logic [16:0]        cfg_min_density,
  input  logic [7:0]         in_pixel_col,
  input  logic [7:0]         in_pixel_row,
  input  logic [7:0]         in_pixel_level,
  input  logic [15:0]        in_candidate_id,
  input  logic signed [15:0] in_start_x,
  input  logic signed [15:0] in_start_y,
  input  logic signed [15:0] in_end_x,
  input  logic signed [15:0] in_end_y,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [15:0]        out_result_id,
  output logic [1:0]         out_verdict,
  output logic [16:0]        out_measured_length,
  output logic [16:0]        out_measured_density,
  output sci_status_t        status
);

  function automatic logic signed [15:0] point_of(input logic signed [15:0] q,
                                                   input logic [17:0] r,
                                                   input logic [16:0] den);
    logic nonneg;
    nonneg = (q > 16'sd0) || ((q == 16'sd0) && (r >= 18'(den)));
    return nonneg ? q : q - 16'sd1 + 16'(r != '0);
  endfunction

  function automatic logic [33:0] step_of(input logic signed [15:0] q,
                                          input logic [17:0] r,
                                          input logic signed [16:0] d,
                                          input logic [17:0] dd);
    logic signed [19:0] s;
    logic signed [19:0] dds;
    dds = $signed({2'b00, dd});
    s   = $signed({2'b00, r}) + 20'($signed({d, 1'b0}));
    if (s >= dds) begin
      return {q + 16'sd1, 18'(s - dds)};
    end else if (s < 20'sd0) begin
      return {q - 16'sd1, 18'(s + dds)};
    end
    return {q, 18'(s)};
  endfunction

  logic [15:0]        id_r;
  logic signed [15:0] ax_r, ay_r;
  logic signed [16:0] dx_r, dy_r;
  logic [SQ_W-1:0]    dx2_r, dy2_r, sq_r, sqsh_r;
  logic [19:0]        rem_r;
  logic [ROOT_W-1:0]  root_r;
  logic [4:0]         rcnt_r;
  logic [N_W-1:0]     n_r;
  logic               short_r;
  logic signed [29:0] pax_r, pay_r;
  logic [16:0]        den_r;
  logic [17:0]        dd_r;
  logic [4:0]         radius_r;
  logic               horiz_r;
  logic signed [31:0] tx_r, ty_r;
  logic signed [15:0] qx_r, qy_r;
  logic [17:0]        rx_r, ry_r;
  logic [N_W-1:0]     i_r;
  logic signed [5:0]  off_r;
  logic               samp_v_r;
  logic [7:0]         rd_r;
  logic [CNT_W-1:0]   samples_r, ink_r;
  logic [16:0]        density_r;
  logic [34:0]        prod_r;
  logic [1:0]         verdict_r;
  logic               out_valid_r, out_valid_nxt;
  logic [15:0]        out_id_r;
  logic [1:0]         out_verdict_r;
  logic [16:0]        out_len_r, out_dens_r;

  logic [7:0]         frame_mem [FRAME_DEPTH];

  logic signed [33:0] dx2_s, dy2_s;
  logic [19:0]        rem_t, trial;
  logic signed [5:0]  rad6;
  logic signed [15:0] px, py, off16, sx, sy;
  logic               in_frame, mem_we;
  logic [ADDR_W-1:0]  rd_addr, wr_addr;
  logic [33:0]        stx, sty;
  logic               div_start, div_done;
  logic [DIV_N_W-1:0] div_dividend, div_quot;
  logic [DIV_D_W-1:0] div_divisor, div_rem;
  logic               neg, rnz;
  logic signed [15:0] qfix;
  logic [17:0]        rfix;
  logic [16:0]        adx, ady;

  assign dx2_s = dx_r * dx_r;
  assign dy2_s = dy_r * dy_r;
  assign rem_t = {rem_r[17:0], sqsh_r[SQ_W-1:SQ_W-2]};
  assign trial = {1'b0, root_r, 2'b01};
  assign rad6  = $signed({1'b0, radius_r});
  assign adx   = dx_r[16] ? 17'(-dx_r) : 17'(dx_r);
  assign ady   = dy_r[16] ? 17'(-dy_r) : 17'(dy_r);

  assign px    = point_of(qx_r, rx_r, den_r);
  assign py    = point_of(qy_r, ry_r, den_r);
  assign off16 = 16'(off_r);
  assign sx    = horiz_r ? px : px + off16;
  assign sy    = horiz_r ? py + off16 : py;
  assign in_frame = !sx[15] && !sy[15] && (sx < 16'(FRAME_WIDTH)) &&
                    (sy < 16'(FRAME_HEIGHT));
  assign rd_addr = ADDR_W'(sy) * ADDR_W'(FRAME_WIDTH) + ADDR_W'(sx);
  assign wr_addr = ADDR_W'(in_pixel_row) * ADDR_W'(FRAME_WIDTH) + ADDR_W'(in_pixel_col);
  assign mem_we  = (cmd == CMD_WRITE) && (32'(in_pixel_col) < FRAME_WIDTH) &&
                   (32'(in_pixel_row) < FRAME_HEIGHT);
  assign stx = step_of(qx_r, rx_r, dx_r, dd_r);
  assign sty = step_of(qy_r, ry_r, dy_r, dd_r);

  assign div_start = (cmd == CMD_DIVX_GO) || (cmd == CMD_DIVY_GO) || (cmd == CMD_DENS_GO);

  always_comb begin
    case (cmd)
      CMD_DIVX_GO: div_dividend = tx_r[31] ? DIV_N_W'(-tx_r) : DIV_N_W'(tx_r);
      CMD_DIVY_GO: div_dividend = ty_r[31] ? DIV_N_W'(-ty_r) : DIV_N_W'(ty_r);
      default:     div_dividend = {ink_r, 16'h0000};
    endcase
    div_divisor = (cmd == CMD_DENS_GO) ? samples_r : dd_r;
    neg  = (cmd == CMD_DIVX_END) ? tx_r[31] : ty_r[31];
    rnz  = (div_rem != '0);
    qfix = neg ? -$signed(16'(div_quot)) - 16'(rnz) : $signed(16'(div_quot));
    rfix = neg ? (rnz ? dd_r - div_rem : '0) : div_rem;
  end

  sci_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_mem[wr_addr] <= in_pixel_level;
    end
    rd_r <= frame_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    case (cmd)
      CMD_CAPTURE: begin
        id_r      <= in_candidate_id;
        ax_r      <= in_start_x;
        ay_r      <= in_start_y;
        dx_r      <= 17'(in_end_x) - 17'(in_start_x);
        dy_r      <= 17'(in_end_y) - 17'(in_start_y);
        density_r <= '0;
      end
      CMD_SQUARE: begin
        dx2_r <= unsigned'(dx2_s);
        dy2_r <= unsigned'(dy2_s);
      end
      CMD_SUM: begin
        sq_r   <= dx2_r + dy2_r;
        sqsh_r <= dx2_r + dy2_r;
        rem_r  <= '0;
        root_r <= '0;
        rcnt_r <= '0;
      end
      CMD_ROOT_STEP: begin
        if (rem_t >= trial) begin
          rem_r  <= rem_t - trial;
          root_r <= {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          rem_r  <= rem_t;
          root_r <= {root_r[ROOT_W-2:0], 1'b0};
        end
        sqsh_r <= {sqsh_r[SQ_W-3:0], 2'b00};
        rcnt_r <= rcnt_r + 1'b1;
      end
      CMD_LENGTH: begin
        n_r     <= N_W'((19'(root_r) + 19'd15) >> 4) +
                   N_W'((root_r[3:0] == 4'd0) && (rem_r != '0));
        short_r <= (root_r < cfg_min_length);
      end
      CMD_SCALE: begin
        pax_r    <= ax_r * $signed({1'b0, n_r});
        pay_r    <= ay_r * $signed({1'b0, n_r});
        den_r    <= {n_r, 4'b0000};
        dd_r     <= {n_r, 5'b00000};
        radius_r <= 5'((9'(cfg_half_width) + 9'd15) >> 4);
        horiz_r  <= (ady <= adx);
      end
      CMD_TERMS: begin
        tx_r <= (32'(pax_r) <<< 1) + $signed({15'd0, den_r});
        ty_r <= (32'(pay_r) <<< 1) + $signed({15'd0, den_r});
      end
      CMD_DIVX_END: begin
        qx_r <= qfix;
        rx_r <= rfix;
      end
      CMD_DIVY_END: begin
        qy_r  <= qfix;
        ry_r  <= rfix;
        i_r   <= '0;
        off_r <= -rad6;
      end
      CMD_SAMPLE: begin
        if (off_r == rad6) begin
          off_r <= -rad6;
          i_r   <= i_r + 1'b1;
          qx_r  <= $signed(stx[33:18]);
          rx_r  <= stx[17:0];
          qy_r  <= $signed(sty[33:18]);
          ry_r  <= sty[17:0];
        end else begin
          off_r <= off_r + 6'sd1;
        end
      end
      CMD_DENS_END: begin
        density_r <= div_quot[16:0];
      end
      CMD_PRODUCT: begin
        prod_r <= 35'(cfg_min_density) * 35'(samples_r);
      end
      CMD_VERDICT: begin
        if (samples_r == '0) begin
          verdict_r <= (cfg_min_density != '0) ? VERDICT_INK : VERDICT_ACCEPT;
        end else begin
          verdict_r <= (35'({ink_r, 16'h0000}) < prod_r) ? VERDICT_INK : VERDICT_ACCEPT;
        end
      end
      CMD_RESULT: begin
        out_id_r      <= id_r;
        out_verdict_r <= short_r ? VERDICT_SHORT : verdict_r;
        out_len_r     <= root_r;
        out_dens_r    <= density_r;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd == CMD_RESULT) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      samp_v_r    <= 1'b0;
      samples_r   <= '0;
      ink_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      samp_v_r    <= (cmd == CMD_SAMPLE) && in_frame;
      if (cmd == CMD_CAPTURE) begin
        samples_r <= '0;
        ink_r     <= '0;
      end else if (samp_v_r) begin
        samples_r <= samples_r + 1'b1;
        ink_r     <= ink_r + CNT_W'(32'(rd_r) < INK_LIMIT);
      end
    end
  end

  assign status.root_last  = (rcnt_r == 5'(ROOT_W - 1));
  assign status.is_short   = (root_r < cfg_min_length);
  assign status.is_zero    = (sq_r == '0);
  assign status.div_done   = div_done;
  assign status.samp_last  = (i_r == n_r) && (off_r == rad6);
  assign status.no_samples = (samples_r == '0);
  assign status.out_free   = !out_valid_r || !out_stall;

  assign out_valid            = out_valid_r;
  assign out_result_id        = out_id_r;
  assign out_verdict          = out_verdict_r;
  assign out_measured_length  = out_len_r;
  assign out_measured_density = out_dens_r;

endmodule

[rtl/sci_ctrl.sv]
// Controller state machine that sequences the datapath for loads and evaluations.
// Depends on sci_pkg for the command and status types.
`timescale 1ns / 1ps

module sci_ctrl import sci_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_req_type,
  input  sci_status_t status,
  output sci_cmd_t    cmd,
  output logic        in_stall
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_SQUARE,
    S_SUM,
    S_ROOT,
    S_LENGTH,
    S_SCALE,
    S_TERMS,
    S_DIVX_GO,
    S_DIVX_WAIT,
    S_DIVY_GO,
    S_DIVY_WAIT,
    S_SAMPLE,
    S_DRAIN,
    S_DENS_GO,
    S_DENS_WAIT,
    S_PRODUCT,
    S_VERDICT,
    S_RESULT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_req_type) begin
            cmd       = CMD_CAPTURE;
            state_nxt = S_SQUARE;
          end else begin
            cmd = CMD_WRITE;
          end
        end
      end
      S_SQUARE: begin
        cmd       = CMD_SQUARE;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd       = CMD_SUM;
        state_nxt = S_ROOT;
      end
      S_ROOT: begin
        cmd = CMD_ROOT_STEP;
        if (status.root_last) begin
          state_nxt = S_LENGTH;
        end
      end
      S_LENGTH: begin
        cmd = CMD_LENGTH;
        if (status.is_short) begin
          state_nxt = S_RESULT;
        end else if (status.is_zero) begin
          state_nxt = S_PRODUCT;
        end else begin
          state_nxt = S_SCALE;
        end
      end
      S_SCALE: begin
        cmd       = CMD_SCALE;
        state_nxt = S_TERMS;
      end
      S_TERMS: begin
        cmd       = CMD_TERMS;
        state_nxt = S_DIVX_GO;
      end
      S_DIVX_GO: begin
        cmd       = CMD_DIVX_GO;
        state_nxt = S_DIVX_WAIT;
      end
      S_DIVX_WAIT: begin
        if (status.div_done) begin
          cmd       = CMD_DIVX_END;
          state_nxt = S_DIVY_GO;
        end
      end
      S_DIVY_GO: begin
        cmd       = CMD_DIVY_GO;
        state_nxt = S_DIVY_WAIT;
      end
      S_DIVY_WAIT: begin
        if (status.div_done) begin
          cmd       = CMD_DIVY_END;
          state_nxt = S_SAMPLE;
        end
      end
      S_SAMPLE: begin
        cmd = CMD_SAMPLE;
        if (status.samp_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DENS_GO;
      end
      S_DENS_GO: begin
        if (status.no_samples) begin
          state_nxt = S_PRODUCT;
        end else begin
          cmd       = CMD_DENS_GO;
          state_nxt = S_DENS_WAIT;
        end
      end
      S_DENS_WAIT: begin
        if (status.div_done) begin
          cmd       = CMD_DENS_END;
          state_nxt = S_PRODUCT;
        end
      end
      S_PRODUCT: begin
        cmd       = CMD_PRODUCT;
        state_nxt = S_VERDICT;
      end
      S_VERDICT: begin
        cmd       = CMD_VERDICT;
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (status.out_free) begin
          cmd       = CMD_RESULT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

[rtl/segment_corridor_ink_check.sv]
// Top level of the segment corridor ink check: configuration registers and glue.
// Depends on sci_pkg, sci_ctrl and sci_dp.
//
//   Channel  Handshake           Payload
//   in       in_valid/in_stall   req_type, pixel load fields, segment fields
//   out      out_valid/out_stall result_id, verdict, measured_length/density
//   cfg      cfg_we              cfg_index, cfg_data
//
// A pixel load leaves the controller idle. An evaluation steps through n+1 points,
// n being the length rounded up in pixels, with 2r+1 sample positions at each, r the
// corridor radius; the sample walk does one frame memory read a cycle.
// A segment rejected as short skips the sample walk. Reset is synchronous and needs
// no clearing pass. A stalled result is held in the output register while
// further pixel loads and one new evaluation proceed.
`timescale 1ns / 1ps

module segment_corridor_ink_check import sci_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_req_type,
  input  logic [7:0]         in_pixel_col,
  input  logic [7:0]         in_pixel_row,
  input  logic [7:0]         in_pixel_level,
  input  logic [15:0]        in_candidate_id,
  input  logic signed [15:0] in_start_x,
  input  logic signed [15:0] in_start_y,
  input  logic signed [15:0] in_end_x,
  input  logic signed [15:0] in_end_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_result_id,
  output logic [1:0]         out_verdict,
  output logic [16:0]        out_measured_length,
  output logic [16:0]        out_measured_density,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [16:0]        cfg_data
);

  logic [16:0] min_length_r;
  logic [7:0]  half_width_r;
  logic [16:0] min_density_r;
  sci_cmd_t    cmd;
  sci_status_t status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_length_r  <= '0;
      half_width_r  <= 8'd16;
      min_density_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_LENGTH:  min_length_r  <= cfg_data;
        CFG_HALF_WIDTH:  half_width_r  <= cfg_data[7:0];
        CFG_MIN_DENSITY: min_density_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  sci_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .status      (status),
    .cmd         (cmd),
    .in_stall    (in_stall)
  );

  sci_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .cfg_min_length       (min_length_r),
    .cfg_half_width       (half_width_r),
    .cfg_min_density      (min_density_r),
    .in_pixel_col         (in_pixel_col),
    .in_pixel_row         (in_pixel_row),
    .in_pixel_level       (in_pixel_level),
    .in_candidate_id      (in_candidate_id),
    .in_start_x           (in_start_x),
    .in_start_y           (in_start_y),
    .in_end_x             (in_end_x),
    .in_end_y             (in_end_y),
    .out_stall            (out_stall),
    .out_valid            (out_valid),
    .out_result_id        (out_result_id),
    .out_verdict          (out_verdict),
    .out_measured_length  (out_measured_length),
    .out_measured_density (out_measured_density),
    .status               (status)
  );

`ifndef ASSERT_OFF
  a_short_no_density: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_verdict == VERDICT_SHORT)) |-> (out_measured_density == '0))
    else $error("Short verdict carries a nonzero density.");

  a_density_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_measured_density <= 17'd65536))
    else $error("Density above one.");

  a_result_from_eval: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("Result appeared without an evaluation in progress.");
`endif

endmodule

[bench/segment_corridor_ink_check_tb.sv]
// Self-checking testbench for the segment corridor ink check.
// Depends on sci_pkg and segment_corridor_ink_check; a behavioural predictor
// with its own frame copy checks every result transfer.
`timescale 1ns / 1ps

module segment_corridor_ink_check_tb;
  import sci_pkg::*;

  // Only a small patch of the frame is loaded; every segment keeps its
  // in-frame samples inside that patch.
  localparam int         PATCH      = 8;
  localparam int         RING_DEPTH = 16;
  localparam int         HOLD_LEN   = 4000;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [15:0] id;
    logic [1:0]  verdict;
    logic [16:0] length;
    logic [16:0] density;
  } verdict_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_req_type = 1'b0;
  logic [7:0]         in_pixel_col = '0;
  logic [7:0]         in_pixel_row = '0;
  logic [7:0]         in_pixel_level = '0;
  logic [15:0]        in_candidate_id = '0;
  logic signed [15:0] in_start_x = '0;
  logic signed [15:0] in_start_y = '0;
  logic signed [15:0] in_end_x = '0;
  logic signed [15:0] in_end_y = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [15:0]        out_result_id;
  logic [1:0]         out_verdict;
  logic [16:0]        out_measured_length;
  logic [16:0]        out_measured_density;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [16:0]        cfg_data = '0;

  logic [7:0]  frame_copy [FRAME_DEPTH];
  logic [16:0] min_len_q;
  logic [7:0]  half_width_q;
  logic [16:0] min_dens_q;
  verdict_t    pending_ring [RING_DEPTH];
  int          put_count = 0;
  int          take_count = 0;
  int          error_count = 0;
  int          burst_left = 0;
  int          hold_req = 0;
  int          hold_ack = 0;
  int          hold_cycles = 0;
  int          stall_mode = 0;

  segment_corridor_ink_check u_dut (.*);

  always #2 clk = ~clk;

  initial begin
    #40_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic longint root_floor(longint sq);
    longint r;
    r = 0;
    for (int b = 17; b >= 0; b--) begin
      if ((r | (64'sd1 << b)) * (r | (64'sd1 << b)) <= sq) r = r | (64'sd1 << b);
    end
    return r;
  endfunction

  function automatic longint nearest(longint num, longint den);
    if (num >= 0) return (2 * num + den) / (2 * den);
    return -((2 * (-num) + den) / (2 * den));
  endfunction

  function automatic verdict_t judge_segment(logic [15:0] id, logic signed [15:0] sx,
                                             logic signed [15:0] sy, logic signed [15:0] ex,
                                             logic signed [15:0] ey);
    verdict_t v;
    longint dx, dy, sq, root, n, m1, radius, px, py, cx, cy, ink, cnt;
    logic along_x;
    dx = longint'(ex) - longint'(sx);
    dy = longint'(ey) - longint'(sy);
    sq = dx * dx + dy * dy;
    root = root_floor(sq);
    ink = 0;
    cnt = 0;
    v.id = id;
    v.length = root[16:0];
    v.density = '0;
    if (root < longint'(min_len_q)) begin
      v.verdict = VERDICT_SHORT;
      return v;
    end
    if (sq != 0) begin
      n = root / 16;
      while (256 * n * n < sq) n++;
      m1 = (n > 0) ? n : 1;
      radius = (longint'(half_width_q) + 15) / 16;
      along_x = ((dy < 0 ? -dy : dy) <= (dx < 0 ? -dx : dx));
      for (longint i = 0; i <= n; i++) begin
        px = nearest(longint'(sx) * m1 + dx * i, 16 * m1);
        py = nearest(longint'(sy) * m1 + dy * i, 16 * m1);
        for (longint k = -radius; k <= radius; k++) begin
          cx = along_x ? px : px + k;
          cy = along_x ? py + k : py;
          if (cx >= 0 && cy >= 0 && cx < FRAME_WIDTH && cy < FRAME_HEIGHT) begin
            cnt++;
            if (frame_copy[cy * FRAME_WIDTH + cx] < INK_LIMIT) ink++;
          end
        end
      end
    end
    if (cnt != 0) v.density = 17'((ink * 65536) / cnt);
    if (cnt == 0) v.verdict = (min_dens_q > 0) ? VERDICT_INK : VERDICT_ACCEPT;
    else v.verdict = (ink * 65536 < longint'(min_dens_q) * cnt) ? VERDICT_INK
                                                                  : VERDICT_ACCEPT;
    return v;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $time);
    error_count++;
  endtask

  always @(posedge clk) begin
    verdict_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (put_count == take_count) begin
        report_mismatch("unexpected result id", out_result_id, -1);
      end else begin
        w = pending_ring[take_count % RING_DEPTH];
        take_count++;
        if (out_result_id !== w.id) report_mismatch("result_id", out_result_id, w.id);
        if (out_verdict !== w.verdict) report_mismatch("verdict", out_verdict, w.verdict);
        if (out_measured_length !== w.length)
          report_mismatch("measured_length", out_measured_length, w.length);
        if (out_measured_density !== w.density)
          report_mismatch("measured_density", out_measured_density, w.density);
      end
    end
  end

  // The receiver stalls on its own pattern, or holds off for a counted stretch.
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_cycles <= HOLD_LEN;
      out_stall <= 1'b1;
    end else if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 1) == 0);
      endcase
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
    end
  end

  task automatic send_item(logic req, logic [7:0] col, logic [7:0] row, logic [7:0] lvl,
                           logic [15:0] id, logic signed [15:0] sx, logic signed [15:0] sy,
                           logic signed [15:0] ex, logic signed [15:0] ey, bit paced);
    int gap;
    if (paced && burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    if (paced) burst_left--;
    in_valid <= 1'b1;
    in_req_type <= req;
    in_pixel_col <= col;
    in_pixel_row <= row;
    in_pixel_level <= lvl;
    in_candidate_id <= id;
    in_start_x <= sx;
    in_start_y <= sy;
    in_end_x <= ex;
    in_end_y <= ey;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!req) begin
      frame_copy[{row, col}] = lvl;
    end else begin
      pending_ring[put_count % RING_DEPTH] = judge_segment(id, sx, sy, ex, ey);
      put_count++;
    end
  endtask

  task automatic send_segment(logic signed [15:0] sx, logic signed [15:0] sy,
                              logic signed [15:0] ex, logic signed [15:0] ey);
    send_item(1'b1, 8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom),
              sx, sy, ex, ey, 1'b1);
  endtask

  task automatic send_pixel(logic [7:0] col, logic [7:0] row, logic [7:0] lvl);
    send_item(1'b0, col, row, lvl, 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), 16'($urandom), 1'b1);
  endtask

  task automatic write_register(logic [1:0] idx, logic [16:0] val);
    in_valid <= 1'b0;
    while (put_count != take_count) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_MIN_LENGTH:  min_len_q = val;
      CFG_HALF_WIDTH:  half_width_q = val[7:0];
      CFG_MIN_DENSITY: min_dens_q = val;
      default: ;
    endcase
  endtask

  task automatic test_frame_load();
    logic [7:0] lvl;
    for (int r = 0; r < PATCH; r++) begin
      for (int c = 0; c < PATCH; c++) begin
        lvl = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 199))
                                          : 8'($urandom_range(200, 255));
        send_item(1'b0, 8'(c), 8'(r), lvl, '0, '0, '0, '0, '0, 1'b0);
      end
    end
    in_valid <= 1'b0;
  endtask

  task automatic test_directed();
    write_register(CFG_MIN_LENGTH, 17'd131071);
    send_segment(16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF);
    send_segment(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF);
    send_segment(16'sd100, 16'sd100, 16'sd100, 16'sd100);
    write_register(CFG_MIN_LENGTH, 17'd0);
    write_register(CFG_HALF_WIDTH, 17'd0);
    send_segment(16'sd0, 16'sd0, 16'sd112, 16'sd112);
    send_segment(16'sd0, 16'sd112, 16'sd112, 16'sd0);
    send_segment(16'sd40, 16'sd40, 16'sd40, 16'sd40);
    send_segment(-16'sd800, -16'sd800, -16'sd80, -16'sd160);
    send_segment(16'sd24, 16'sd8, 16'sd40, 16'sd8);
    send_segment(-16'sd8, -16'sd24, -16'sd8, 16'sd104);
    write_register(CFG_HALF_WIDTH, 17'd255);
    send_segment(-16'sd320, -16'sd144, 16'sd112, -16'sd144);
    send_segment(-16'sd144, -16'sd320, -16'sd144, 16'sd112);
    send_segment(16'sd4400, 16'sh8000, 16'sh7FFF, 16'sh7FFF);
    write_register(CFG_MIN_DENSITY, 17'd65536);
    write_register(CFG_HALF_WIDTH, 17'd16);
    send_segment(16'sd0, 16'sd0, 16'sd112, 16'sd64);
    send_segment(-16'sd400, -16'sd400, -16'sd100, -16'sd380);
    write_register(CFG_MIN_DENSITY, 17'd131071);
    send_segment(16'sd0, 16'sd16, 16'sd112, 16'sd16);
    write_register(CFG_MIN_DENSITY, 17'd0);
    write_register(CFG_HALF_WIDTH, 17'd0);
    write_register(CFG_MIN_LENGTH, 17'd160);
    send_segment(-16'sd96, -16'sd128, 16'sd0, 16'sd0);
    send_segment(-16'sd96, -16'sd127, 16'sd0, 16'sd0);
    write_register(CFG_MIN_LENGTH, 17'd0);
    write_register(CFG_HALF_WIDTH, 17'd16);
    send_pixel(8'd7, 8'd7, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd0, 8'd0, 8'd199);
    send_pixel(8'd7, 8'd0, 8'd200);
    write_register(CFG_UNUSED, 17'h1FFFF);
    send_segment(16'sd0, 16'sd0, 16'sd112, 16'sd0);
  endtask

  task automatic test_random(int count);
    logic signed [15:0] sx, sy, ex, ey;
    int pick;
    for (int k = 0; k < count; k++) begin
      if (k % 15 == 0) begin
        write_register(CFG_MIN_LENGTH, ($urandom_range(0, 3) == 0) ? 17'($urandom_range(0, 1600))
                                                                      : 17'd0);
        write_register(CFG_HALF_WIDTH, 17'($urandom_range(0, 48)));
        write_register(CFG_MIN_DENSITY, 17'($urandom_range(0, 65536)));
      end
      pick = $urandom_range(0, 7);
      if (pick < 2) begin
        send_pixel(8'($urandom_range(0, PATCH - 1)), 8'($urandom_range(0, PATCH - 1)),
                   8'($urandom));
      end else if (pick == 2) begin
        sx = 16'(int'($urandom_range(4400, 8000)));
        ex = 16'(int'($urandom_range(4400, 8000)));
        sy = 16'(int'($urandom_range(0, 16000)) - 8000);
        ey = 16'(int'($urandom_range(0, 16000)) - 8000);
        send_segment(sx, sy, ex, ey);
      end else begin
        sx = 16'(int'($urandom_range(0, 704)) - 640);
        sy = 16'(int'($urandom_range(0, 704)) - 640);
        ex = 16'(int'($urandom_range(0, 704)) - 640);
        ey = 16'(int'($urandom_range(0, 704)) - 640);
        send_segment(sx, sy, ex, ey);
      end
    end
  endtask

  task automatic test_backpressure();
    write_register(CFG_HALF_WIDTH, 17'd16);
    hold_req++;
    for (int k = 0; k < 6; k++) begin
      send_segment(-16'sd320, 16'sd16, 16'sd64, 16'sd48);
      send_pixel(8'($urandom_range(0, PATCH - 1)), 8'($urandom_range(0, PATCH - 1)),
                 8'($urandom));
    end
  endtask

  initial begin
    min_len_q = '0;
    half_width_q = 8'd16;
    min_dens_q = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_frame_load();
    test_directed();
    test_backpressure();
    test_random(45);
    in_valid <= 1'b0;
    while (put_count != take_count) @(posedge clk);
    repeat (200) @(posedge clk);
    if (error_count == 0 && put_count == take_count) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
